/* sv/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 3;

    localparam logic [CP_W-1:0]    REPL_CP      = 21'h00003F;
    localparam logic [CP_W-1:0]    MIN_CP_3     = 21'h000800;
    localparam logic [CP_W-1:0]    MIN_CP_4     = 21'h010000;
    localparam logic [CP_W-1:0]    MAX_CP       = 21'h10FFFF;
    localparam logic [CP_W-1:0]    SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0]    SURR_HI      = 21'h00DFFF;
    localparam logic [7:0]         LEAD2_LO     = 8'hC2;
    localparam logic [7:0]         LEAD3_LO     = 8'hE0;
    localparam logic [7:0]         LEAD4_LO     = 8'hF0;
    localparam logic [7:0]         LEAD4_HI     = 8'hF4;
    localparam logic [COUNT_W-1:0] LEN_NONE     = 3'd0;
    localparam logic [COUNT_W-1:0] LEN_1        = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_2        = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_3        = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_4        = 3'd4;

    // Results caused by one byte: cnt results, all '?' except the last,
    // which carries the fields below.
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] byte_count;
        logic               repl;
    } burst_t;

endpackage

/* sv/utf8d_decode.sv */
// Sequence state and per-byte decode into a burst of results.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   in_byte,
    output burst_t       burst
);

    logic [COUNT_W-1:0] seq_length_reg, seq_length_next;
    logic [1:0]         bytes_seen_reg, bytes_seen_next;
    logic [CP_W-1:0]    value_accum_reg, value_accum_next;

    logic [COUNT_W-1:0] slen;
    logic [COUNT_W-1:0] seen;
    logic [COUNT_W-1:0] pre;
    logic [CP_W-1:0]    v;
    logic               is_cont;
    logic               bad;

    always_comb
    begin
        slen    = (seq_length_reg >= LEN_2 && seq_length_reg <= LEN_4) ? seq_length_reg
                                                                        : LEN_NONE;
        is_cont = (in_byte[7:6] == 2'b10);
        seen    = {1'b0, bytes_seen_reg} + LEN_1;
        v       = {value_accum_reg[CP_W-7:0], in_byte[5:0]};
        bad     = (slen == LEN_3 && v < MIN_CP_3) || (slen == LEN_4 && v < MIN_CP_4) ||
                  (v > MAX_CP) || (v >= SURR_LO && v <= SURR_HI);
        pre     = (slen != LEN_NONE) ? {1'b0, bytes_seen_reg} : LEN_NONE;

        seq_length_next  = LEN_NONE;
        bytes_seen_next  = 2'd0;
        value_accum_next = '0;
        burst.cnt        = LEN_NONE;
        burst.cp         = REPL_CP;
        burst.byte_count = LEN_1;
        burst.repl       = 1'b1;

        if (slen != LEN_NONE && is_cont)
        begin
            if (seen < slen)
            begin
                seq_length_next  = slen;
                bytes_seen_next  = seen[1:0];
                value_accum_next = v;
            end
            else if (bad)
            begin
                burst.cnt = slen;
            end
            else
            begin
                burst.cnt        = LEN_1;
                burst.cp         = v;
                burst.byte_count = slen;
                burst.repl       = 1'b0;
            end
        end
        else
        begin
            // held bytes of an interrupted sequence each give '?' first
            priority if (!in_byte[7])
            begin
                burst.cnt  = pre + LEN_1;
                burst.cp   = {13'd0, in_byte};
                burst.repl = 1'b0;
            end
            else if (in_byte >= LEAD2_LO && in_byte < LEAD3_LO)
            begin
                burst.cnt        = pre;
                seq_length_next  = LEN_2;
                bytes_seen_next  = 2'd1;
                value_accum_next = {16'd0, in_byte[4:0]};
            end
            else if (in_byte >= LEAD3_LO && in_byte < LEAD4_LO)
            begin
                burst.cnt        = pre;
                seq_length_next  = LEN_3;
                bytes_seen_next  = 2'd1;
                value_accum_next = {17'd0, in_byte[3:0]};
            end
            else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI)
            begin
                burst.cnt        = pre;
                seq_length_next  = LEN_4;
                bytes_seen_next  = 2'd1;
                value_accum_next = {18'd0, in_byte[2:0]};
            end
            else
            begin
                burst.cnt = pre + LEN_1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg  <= LEN_NONE;
            bytes_seen_reg  <= 2'd0;
            value_accum_reg <= '0;
        end
        else if (fire)
        begin
            seq_length_reg  <= seq_length_next;
            bytes_seen_reg  <= bytes_seen_next;
            value_accum_reg <= value_accum_next;
        end
    end

endmodule

/* sv/utf8d_out.sv */
// Result register: plays out a burst of results, one per cycle while m_tready is high.
module utf8d_out
    import utf8d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  burst_t                burst,
    output logic                  load_ok,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CP_W+COUNT_W-1:0] m_tdata,  // code_point, byte_count
    output logic                  m_tuser,    // is_replacement
    output logic                  m_tlast     // last_of_run
);

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [CP_W-1:0]    cp_reg;
    logic [COUNT_W-1:0] bc_reg;
    logic               repl_reg;
    logic               pop;
    logic               final_one;

    always_comb
    begin
        final_one = (cnt_reg == LEN_1);
        m_tvalid  = (cnt_reg != LEN_NONE);
        pop       = m_tvalid && m_tready;
        load_ok   = !m_tvalid || (final_one && m_tready);
        m_tlast   = final_one;
        m_tdata   = final_one ? {bc_reg, cp_reg} : {LEN_1, REPL_CP};
        m_tuser   = final_one ? repl_reg : 1'b1;

        if (load)
            cnt_next = burst.cnt;
        else if (pop)
            cnt_next = cnt_reg - LEN_1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= LEN_NONE;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= burst.cp;
            bc_reg   <= burst.byte_count;
            repl_reg <= burst.repl;
        end
    end

endmodule

/* sv/utf8_stream_decoder_top.sv */
// Top level of the UTF-8 stream decoder.
// Bytes enter on the s_ stream and code points leave on the m_ stream. A byte is
// registered, decoded combinationally against the open-sequence state, and its
// results go to the output register, which plays them out one per cycle while
// m_tready is high. A clean stream (zero or one result per byte) runs at one byte
// per clock with a ready sink; a byte with more results (up to four replacements)
// holds the input while they drain. m_tlast marks the last result of a byte.
module utf8_stream_decoder_top
    import utf8d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // in_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [CP_W+COUNT_W-1:0] m_tdata,   // code_point[20:0], byte_count[23:21]
    output logic                    m_tuser,   // is_replacement
    output logic                    m_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       load_ok;
    logic       fire;
    burst_t     burst;

    assign fire     = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    utf8d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .burst   (burst)
    );

    utf8d_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .burst    (burst),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* bench/utf8_stream_decoder_top_test.sv */
// Self-checking bench for the UTF-8 stream decoder: directed and random byte streams.
module utf8_stream_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] nbytes;
        logic               repl;
        logic               last;
    } cp_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = 8'h00;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CP_W+COUNT_W-1:0] m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;

    // decoder state mirror
    logic [COUNT_W-1:0] dec_len = LEN_NONE;
    logic [1:0]         dec_seen = 2'd0;
    logic [CP_W-1:0]    dec_acc = '0;

    cp_result_t pending_cps[$];
    int         n_fail = 0;
    int         bytes_sent = 0;
    int         quiet_cycles = 0;
    int         hold_req = 0;
    bit         src_quiet = 1'b0;
    bit         sink_quiet = 1'b0;

    utf8_stream_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Work out the results one accepted byte causes and queue them.
    function automatic void decode_byte(input logic [7:0] b);
        cp_result_t      outs[4];
        int              n;
        int              i;
        int              k;
        logic [CP_W-1:0] acc_next;
        bit              bad;
        bit              done;
        n = 0;
        done = 1'b0;
        if (dec_len < LEN_2 || dec_len > LEN_4)
        begin
            dec_len = LEN_NONE;
            dec_seen = 2'd0;
            dec_acc = '0;
        end
        if (dec_len != LEN_NONE)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc_next = {dec_acc[CP_W-7:0], b[5:0]};
                if (int'(dec_seen) + 1 < int'(dec_len))
                begin
                    dec_seen = dec_seen + 2'd1;
                    dec_acc = acc_next;
                end
                else
                begin
                    bad = (dec_len == LEN_3 && acc_next < MIN_CP_3) ||
                          (dec_len == LEN_4 && acc_next < MIN_CP_4) ||
                          acc_next > MAX_CP ||
                          (acc_next >= SURR_LO && acc_next <= SURR_HI);
                    if (bad)
                    begin
                        for (i = 0; i < int'(dec_len); i++)
                        begin
                            outs[n] = '{REPL_CP, LEN_1, 1'b1, 1'b0};
                            n++;
                        end
                    end
                    else
                    begin
                        outs[n] = '{acc_next, dec_len, 1'b0, 1'b0};
                        n++;
                    end
                    dec_len = LEN_NONE;
                    dec_seen = 2'd0;
                    dec_acc = '0;
                end
                done = 1'b1;
            end
            else
            begin
                // sequence broken: one '?' per byte held, then decode b as a fresh byte
                k = int'(dec_seen);
                for (i = 0; i < k; i++)
                begin
                    outs[n] = '{REPL_CP, LEN_1, 1'b1, 1'b0};
                    n++;
                end
                dec_len = LEN_NONE;
                dec_seen = 2'd0;
                dec_acc = '0;
            end
        end
        if (!done)
        begin
            if (b < 8'h80)
            begin
                outs[n] = '{CP_W'(b), LEN_1, 1'b0, 1'b0};
                n++;
            end
            else if (b >= LEAD2_LO && b < LEAD3_LO)
            begin
                dec_len = LEN_2;
                dec_seen = 2'd1;
                dec_acc = CP_W'(b[4:0]);
            end
            else if (b >= LEAD3_LO && b < LEAD4_LO)
            begin
                dec_len = LEN_3;
                dec_seen = 2'd1;
                dec_acc = CP_W'(b[3:0]);
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                dec_len = LEN_4;
                dec_seen = 2'd1;
                dec_acc = CP_W'(b[2:0]);
            end
            else
            begin
                outs[n] = '{REPL_CP, LEN_1, 1'b1, 1'b0};
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            outs[i].last = (i == n - 1);
            pending_cps.push_back(outs[i]);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Encode cp as a len-byte sequence and send only the first keep bytes.
    task automatic send_encoded(input logic [CP_W-1:0] cp, input int len, input int keep);
        int              i;
        logic [7:0]      b;
        logic [CP_W-1:0] shifted;
        for (i = 0; i < keep; i++)
        begin
            shifted = cp >> (6 * (len - 1 - i));
            if (i == 0)
            begin
                unique case (len)
                    1:       b = {1'b0, cp[6:0]};
                    2:       b = {3'b110, shifted[4:0]};
                    3:       b = {4'b1110, shifted[3:0]};
                    default: b = {5'b11110, shifted[2:0]};
                endcase
            end
            else
            begin
                b = {2'b10, shifted[5:0]};
            end
            send_byte(b);
        end
    endtask

    task automatic send_random_unit();
        int              r;
        int              len;
        logic [CP_W-1:0] cp;
        r = $urandom_range(0, 99);
        len = $urandom_range(2, 4);
        cp = CP_W'($urandom);
        if (r < 30)
            send_encoded(CP_W'($urandom_range(0, 8'h7F)), 1, 1);
        else if (r < 45)
            send_encoded(CP_W'($urandom_range(12'h080, 12'h7FF)), 2, 2);
        else if (r < 60)
            send_encoded(CP_W'($urandom_range(16'h0800, 16'hFFFF)), 3, 3);
        else if (r < 72)
            send_encoded(CP_W'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4);
        else if (r < 80)
            // raw payload: hits overlong, out-of-range and bad leads
            send_encoded(cp, len, len);
        else if (r < 90)
            send_encoded(cp, len, $urandom_range(1, len - 1));
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_ascii();
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    task automatic test_valid_sequences();
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hE0); send_byte(8'hA0); send_byte(8'h80);
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
    endtask

    task automatic test_bad_leads();
        send_byte(8'h80);
        send_byte(8'hC1);
        send_byte(8'hF5);
    endtask

    task automatic test_interrupted_sequences();
        // three bytes held, then ASCII: four results from one request
        send_byte(8'hF1); send_byte(8'h80); send_byte(8'h80); send_byte(8'h41);
        // new lead replaces an open sequence, which then completes
        send_byte(8'hC3); send_byte(8'hC3); send_byte(8'hA9);
    endtask

    task automatic test_rejected_sequences();
        send_byte(8'hE0); send_byte(8'h9F); send_byte(8'hBF);
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
    endtask

    task automatic test_random_stream(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_random_unit();
    endtask

    // Sink holds off while the source keeps offering, so the input backs up.
    task automatic test_sink_hold(input int n);
        src_quiet = 1'b1;
        hold_req <= hold_req + 1;
        test_random_stream(n);
        src_quiet = 1'b0;
    endtask

    task automatic test_full_rate(input int n);
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        test_random_stream(n);
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial
    begin : sink_ready
        int hold_seen;
        int stall;
        hold_seen = 0;
        forever
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = sink_quiet ? 0 : idle_len();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cp_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cps.size() == 0)
            begin
                $error("unexpected result: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                n_fail++;
            end
            else
            begin
                exp_r = pending_cps.pop_front();
                if (m_tdata[CP_W-1:0] !== exp_r.cp)
                begin
                    $error("code_point: expected %h, got %h", exp_r.cp, m_tdata[CP_W-1:0]);
                    n_fail++;
                end
                if (m_tdata[CP_W +: COUNT_W] !== exp_r.nbytes)
                begin
                    $error("byte_count: expected %0d, got %0d",
                           exp_r.nbytes, m_tdata[CP_W +: COUNT_W]);
                    n_fail++;
                end
                if (m_tuser !== exp_r.repl)
                begin
                    $error("is_replacement: expected %b, got %b", exp_r.repl, m_tuser);
                    n_fail++;
                end
                if (m_tlast !== exp_r.last)
                begin
                    $error("last_of_run: expected %b, got %b", exp_r.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii();
        test_valid_sequences();
        test_bad_leads();
        test_interrupted_sequences();
        test_rejected_sequences();
        test_random_stream(240);
        test_sink_hold(50);
        test_full_rate(50);
        s_tvalid <= 1'b0;
        while (pending_cps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_fail == 0 && pending_cps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8d_out.sv
sv/utf8_stream_decoder_top.sv
bench/utf8_stream_decoder_top_test.sv
